// ===== sv/mobius_transform_pixel_map_assert.svh =====
// Assertion macros used by the checker file.
`ifndef MOBIUS_TRANSFORM_PIXEL_MAP_ASSERT_SVH
`define MOBIUS_TRANSFORM_PIXEL_MAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define MTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MTP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mtp_pkg.sv =====
package mtp_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W  = 16;
  localparam int CNT_W   = 11;
  localparam int IDX_W   = 4;

  // Arithmetic widths.
  localparam int PROD_W  = 2 * COORD_W;
  localparam int NUM_W   = PROD_W + 2;
  localparam int HALF_W  = NUM_W / 2;
  localparam int WPROD_W = 2 * NUM_W;
  localparam int SUM_W   = WPROD_W + 1;
  localparam int QUO_W   = COORD_W + 1;
  localparam int N_DIV   = QUO_W;
  localparam int REM_W   = SUM_W + QUO_W - 1;

  // Pipeline stage numbers.
  localparam int ST_COMB = 5;
  localparam int ST_ABS  = 6;
  localparam int ST_LAST = ST_ABS + N_DIV;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_A_RE = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_A_IM = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_B_RE = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_B_IM = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_C_RE = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_C_IM = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_D_RE = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_D_IM = IDX_W'(7);

  // Marker values of an invalid pixel.
  localparam longint MARK_RAW = -(longint'(1000) <<< FRAC_W);
  localparam longint COORD_LO = -(longint'(1) <<< (COORD_W - 1));
  localparam logic signed [COORD_W-1:0] MARK_COORD =
    COORD_W'((MARK_RAW < COORD_LO) ? COORD_LO : MARK_RAW);
  localparam logic signed [CNT_W-1:0] MARK_CNT = CNT_W'(-1000);

  typedef struct packed {
    logic signed [COORD_W-1:0] a_re;
    logic signed [COORD_W-1:0] a_im;
    logic signed [COORD_W-1:0] b_re;
    logic signed [COORD_W-1:0] b_im;
    logic signed [COORD_W-1:0] c_re;
    logic signed [COORD_W-1:0] c_im;
    logic signed [COORD_W-1:0] d_re;
    logic signed [COORD_W-1:0] d_im;
  } coef_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] count;
    logic                    inv;
    logic                    pole;
    logic                    neg_re;
    logic                    neg_im;
  } side_t;

endpackage

// ===== sv/mtp_if.sv =====
interface mtp_in_if;
  import mtp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_in;
  logic signed [COORD_W-1:0] y_in;
  logic signed [CNT_W-1:0]   count_in;

  modport source(output valid, x_in, y_in, count_in, input ready);
  modport sink(input valid, x_in, y_in, count_in, output ready);
endinterface

interface mtp_out_if;
  import mtp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_out;
  logic signed [COORD_W-1:0] y_out;
  logic signed [CNT_W-1:0]   count_out;
  logic                      invalid_pixel;
  logic                      pole_hit;
  logic                      saturated;

  modport source(output valid, x_out, y_out, count_out, invalid_pixel, pole_hit, saturated,
                 input ready);
  modport sink(input valid, x_out, y_out, count_out, invalid_pixel, pole_hit, saturated,
               output ready);
endinterface

// ===== sv/mtp_cfg_regs.sv =====
module mtp_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [mtp_pkg::IDX_W-1:0]    cfg_idx,
  input  logic [mtp_pkg::COORD_W-1:0]  cfg_wdata,
  output mtp_pkg::coef_t               coef
);
  import mtp_pkg::*;

  coef_t coef_r;
  coef_t coef_nxt;

  always_comb begin
    coef_nxt = coef_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_A_RE: coef_nxt.a_re = cfg_wdata;
        REG_A_IM: coef_nxt.a_im = cfg_wdata;
        REG_B_RE: coef_nxt.b_re = cfg_wdata;
        REG_B_IM: coef_nxt.b_im = cfg_wdata;
        REG_C_RE: coef_nxt.c_re = cfg_wdata;
        REG_C_IM: coef_nxt.c_im = cfg_wdata;
        REG_D_RE: coef_nxt.d_re = cfg_wdata;
        REG_D_IM: coef_nxt.d_im = cfg_wdata;
        default:  coef_nxt = coef_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

// ===== sv/mtp_front.sv =====
module mtp_front (
  input  logic                              clk,
  input  logic                              en,
  input  mtp_pkg::coef_t                    coef,
  input  logic signed [mtp_pkg::COORD_W-1:0] x,
  input  logic signed [mtp_pkg::COORD_W-1:0] y,
  output logic signed [mtp_pkg::NUM_W-1:0]   nr,
  output logic signed [mtp_pkg::NUM_W-1:0]   ni,
  output logic signed [mtp_pkg::NUM_W-1:0]   mr,
  output logic signed [mtp_pkg::NUM_W-1:0]   mi
);
  import mtp_pkg::*;

  logic signed [PROD_W-1:0] arx_r, aiy_r, ary_r, aix_r;
  logic signed [PROD_W-1:0] crx_r, ciy_r, cry_r, cix_r;
  logic signed [NUM_W-1:0]  nr_r, ni_r, mr_r, mi_r;

  always_ff @(posedge clk) begin
    if (en) begin
      arx_r <= PROD_W'(coef.a_re) * PROD_W'(x);
      aiy_r <= PROD_W'(coef.a_im) * PROD_W'(y);
      ary_r <= PROD_W'(coef.a_re) * PROD_W'(y);
      aix_r <= PROD_W'(coef.a_im) * PROD_W'(x);
      crx_r <= PROD_W'(coef.c_re) * PROD_W'(x);
      ciy_r <= PROD_W'(coef.c_im) * PROD_W'(y);
      cry_r <= PROD_W'(coef.c_re) * PROD_W'(y);
      cix_r <= PROD_W'(coef.c_im) * PROD_W'(x);
    end
  end

  // The constant terms b and d are scaled up to match the product format.
  always_ff @(posedge clk) begin
    if (en) begin
      nr_r <= NUM_W'(arx_r) - NUM_W'(aiy_r) + (NUM_W'(coef.b_re) <<< FRAC_W);
      ni_r <= NUM_W'(ary_r) + NUM_W'(aix_r) + (NUM_W'(coef.b_im) <<< FRAC_W);
      mr_r <= NUM_W'(crx_r) - NUM_W'(ciy_r) + (NUM_W'(coef.d_re) <<< FRAC_W);
      mi_r <= NUM_W'(cry_r) + NUM_W'(cix_r) + (NUM_W'(coef.d_im) <<< FRAC_W);
    end
  end

  assign nr = nr_r;
  assign ni = ni_r;
  assign mr = mr_r;
  assign mi = mi_r;

endmodule

// ===== sv/mtp_wmul.sv =====
module mtp_wmul (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [mtp_pkg::NUM_W-1:0]    a,
  input  logic signed [mtp_pkg::NUM_W-1:0]    b,
  output logic signed [mtp_pkg::WPROD_W-1:0]  p
);
  import mtp_pkg::*;

  logic        [HALF_W-1:0]         a_lo, b_lo;
  logic signed [NUM_W-HALF_W-1:0]   a_hi, b_hi;
  logic        [2*HALF_W-1:0]       ll_r;
  logic signed [2*HALF_W:0]         lh_r, hl_r;
  logic signed [2*HALF_W-1:0]       hh_r;
  logic signed [WPROD_W-1:0]        p_r;

  assign a_lo = a[HALF_W-1:0];
  assign b_lo = b[HALF_W-1:0];
  assign a_hi = a[NUM_W-1:HALF_W];
  assign b_hi = b[NUM_W-1:HALF_W];

  // Low halves are unsigned, high halves carry the sign.
  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= (2*HALF_W)'(a_lo) * (2*HALF_W)'(b_lo);
      lh_r <= (2*HALF_W+1)'($signed({1'b0, a_lo})) * (2*HALF_W+1)'(b_hi);
      hl_r <= (2*HALF_W+1)'(a_hi) * (2*HALF_W+1)'($signed({1'b0, b_lo}));
      hh_r <= (2*HALF_W)'(a_hi) * (2*HALF_W)'(b_hi);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= (WPROD_W'(hh_r) <<< (2*HALF_W))
           + ((WPROD_W'(lh_r) + WPROD_W'(hl_r)) <<< HALF_W)
           + $signed(WPROD_W'(ll_r));
    end
  end

  assign p = p_r;

endmodule

// ===== sv/mtp_div.sv =====
module mtp_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [mtp_pkg::SUM_W-1:0]     num,
  input  logic [mtp_pkg::SUM_W-1:0]     den,
  output logic [mtp_pkg::QUO_W-1:0]     quo
);
  import mtp_pkg::*;

  logic [REM_W-1:0] rem_r [N_DIV-1];
  logic [REM_W-1:0] dsh_r [N_DIV-1];
  logic [QUO_W-1:0] q_r   [N_DIV];

  // Restoring division, one quotient bit per stage, most significant first.
  // The top quotient bit only flags a quotient too large for the output.
  for (genvar j = 0; j < N_DIV; j++) begin : g_stage
    logic [REM_W-1:0] r_i;
    logic [REM_W-1:0] d_i;
    logic [QUO_W-1:0] q_i;
    logic             ge;

    if (j == 0) begin : g_first
      assign r_i = REM_W'({num, {FRAC_W{1'b0}}});
      assign d_i = REM_W'(den) << (QUO_W - 1);
      assign q_i = '0;
    end else begin : g_next
      assign r_i = rem_r[j-1];
      assign d_i = dsh_r[j-1];
      assign q_i = q_r[j-1];
    end

    assign ge = (r_i >= d_i);

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j] <= {q_i[QUO_W-2:0], ge};
      end
    end

    if (j < N_DIV - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? (r_i - d_i) : r_i;
          dsh_r[j] <= d_i >> 1;
        end
      end
    end
  end

  assign quo = q_r[N_DIV-1];

endmodule

// ===== sv/mobius_transform_pixel_map.sv =====
// Moebius map w = (a*z + b) / (c*z + d) on a stream of map pixels in signed
// Q16.16. One word enters per clock unless the output is held; the exact divider
// resolves one quotient bit per stage over 33 stages, behind six stages of
// products and sums. A word held at the output freezes the whole pipeline until
// it is taken. Coefficients must be written through the cfg port while no
// pixel is in flight; the block does not enforce this. A negative count yields
// the invalid marker, a zero denominator yields zero with pole_hit.
module mobius_transform_pixel_map (
  input  logic                          clk,
  input  logic                          rst_n,
  mtp_in_if.sink                        in_ch,
  mtp_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [mtp_pkg::IDX_W-1:0]     cfg_idx,
  input  logic [mtp_pkg::COORD_W-1:0]   cfg_wdata
);
  import mtp_pkg::*;

  coef_t                      coef;
  logic                       pipe_en;
  logic [ST_LAST:1]           vld_r;
  side_t                      side_r [1:ST_LAST];
  logic signed [NUM_W-1:0]    nr, ni, mr, mi;
  logic signed [WPROD_W-1:0]  nrmr, nimi, nimr, nrmi, mrmr, mimi;
  logic signed [SUM_W-1:0]    pre_r, pim_r;
  logic        [SUM_W-1:0]    den_r;
  logic        [SUM_W-1:0]    mag_re_r, mag_im_r, den6_r;
  logic        [QUO_W-1:0]    quo_re, quo_im;
  logic [COORD_W:0]           fin_re, fin_im;

  logic                       out_valid_r;
  logic signed [COORD_W-1:0]  x_out_r, y_out_r;
  logic signed [CNT_W-1:0]    count_out_r;
  logic                       inv_out_r, pole_out_r, sat_out_r;

  // Saturated signed result from an unsigned quotient; top bit is the flag.
  function automatic logic [COORD_W:0] sat_coord(input logic [QUO_W-1:0] q,
                                                  input logic neg);
    logic [COORD_W-1:0] lim;
    logic [COORD_W-1:0] m;
    logic               over;
    lim  = neg ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    over = q[QUO_W-1] || (q[COORD_W-1:0] > lim);
    m    = over ? lim : q[COORD_W-1:0];
    return {over, (neg ? (~m + COORD_W'(1)) : m)};
  endfunction

  assign pipe_en     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = pipe_en;

  mtp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .coef      (coef)
  );

  mtp_front u_front (
    .clk  (clk),
    .en   (pipe_en),
    .coef (coef),
    .x    (in_ch.x_in),
    .y    (in_ch.y_in),
    .nr   (nr),
    .ni   (ni),
    .mr   (mr),
    .mi   (mi)
  );

  mtp_wmul u_nrmr (.clk(clk), .en(pipe_en), .a(nr), .b(mr), .p(nrmr));
  mtp_wmul u_nimi (.clk(clk), .en(pipe_en), .a(ni), .b(mi), .p(nimi));
  mtp_wmul u_nimr (.clk(clk), .en(pipe_en), .a(ni), .b(mr), .p(nimr));
  mtp_wmul u_nrmi (.clk(clk), .en(pipe_en), .a(nr), .b(mi), .p(nrmi));
  mtp_wmul u_mrmr (.clk(clk), .en(pipe_en), .a(mr), .b(mr), .p(mrmr));
  mtp_wmul u_mimi (.clk(clk), .en(pipe_en), .a(mi), .b(mi), .p(mimi));

  // n * conj(m) and |m|^2.
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      pre_r <= SUM_W'(nrmr) + SUM_W'(nimi);
      pim_r <= SUM_W'(nimr) - SUM_W'(nrmi);
      den_r <= SUM_W'($unsigned(mrmr)) + SUM_W'($unsigned(mimi));
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      mag_re_r <= pre_r[SUM_W-1] ? SUM_W'(-pre_r) : SUM_W'(pre_r);
      mag_im_r <= pim_r[SUM_W-1] ? SUM_W'(-pim_r) : SUM_W'(pim_r);
      den6_r   <= den_r;
    end
  end

  mtp_div u_div_re (.clk(clk), .en(pipe_en), .num(mag_re_r), .den(den6_r), .quo(quo_re));
  mtp_div u_div_im (.clk(clk), .en(pipe_en), .num(mag_im_r), .den(den6_r), .quo(quo_im));

  // Count, invalid mark, pole and signs travel alongside the arithmetic.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[ST_LAST-1:1], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      side_r[1].count  <= in_ch.count_in;
      side_r[1].inv    <= in_ch.count_in[CNT_W-1];
      side_r[1].pole   <= 1'b0;
      side_r[1].neg_re <= 1'b0;
      side_r[1].neg_im <= 1'b0;
      for (int i = 2; i <= ST_LAST; i++) begin
        if (i == ST_ABS) begin
          side_r[i].count  <= side_r[i-1].count;
          side_r[i].inv    <= side_r[i-1].inv;
          side_r[i].pole   <= (den_r == '0);
          side_r[i].neg_re <= pre_r[SUM_W-1];
          side_r[i].neg_im <= pim_r[SUM_W-1];
        end else begin
          side_r[i] <= side_r[i-1];
        end
      end
    end
  end

  assign fin_re = sat_coord(quo_re, side_r[ST_LAST].neg_re);
  assign fin_im = sat_coord(quo_im, side_r[ST_LAST].neg_im);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= vld_r[ST_LAST];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      priority if (side_r[ST_LAST].inv) begin
        x_out_r     <= MARK_COORD;
        y_out_r     <= MARK_COORD;
        count_out_r <= MARK_CNT;
        inv_out_r   <= 1'b1;
        pole_out_r  <= 1'b0;
        sat_out_r   <= 1'b0;
      end else if (side_r[ST_LAST].pole) begin
        x_out_r     <= '0;
        y_out_r     <= '0;
        count_out_r <= side_r[ST_LAST].count;
        inv_out_r   <= 1'b0;
        pole_out_r  <= 1'b1;
        sat_out_r   <= 1'b0;
      end else begin
        x_out_r     <= fin_re[COORD_W-1:0];
        y_out_r     <= fin_im[COORD_W-1:0];
        count_out_r <= side_r[ST_LAST].count;
        inv_out_r   <= 1'b0;
        pole_out_r  <= 1'b0;
        sat_out_r   <= fin_re[COORD_W] || fin_im[COORD_W];
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.x_out         = x_out_r;
  assign out_ch.y_out         = y_out_r;
  assign out_ch.count_out     = count_out_r;
  assign out_ch.invalid_pixel = inv_out_r;
  assign out_ch.pole_hit      = pole_out_r;
  assign out_ch.saturated     = sat_out_r;

endmodule

// ===== sv/mtp_checker.sv =====
`include "mobius_transform_pixel_map_assert.svh"

module mtp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [mtp_pkg::COORD_W-1:0] x_out,
  input logic signed [mtp_pkg::COORD_W-1:0] y_out,
  input logic signed [mtp_pkg::CNT_W-1:0]   count_out,
  input logic                               invalid_pixel,
  input logic                               pole_hit,
  input logic                               saturated
);
  import mtp_pkg::*;

  `MTP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(x_out) && $stable(y_out) && $stable(count_out), "output word changed while stalled")
  `MTP_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready, "input stalled with empty output")
  `MTP_ASSERT_NOW(a_invalid_word, clk, rst_n, out_valid && invalid_pixel, !pole_hit && !saturated && count_out == MARK_CNT && x_out == MARK_COORD && y_out == MARK_COORD, "bad invalid pixel word")
  `MTP_ASSERT_NOW(a_pole_word, clk, rst_n, out_valid && pole_hit, x_out == '0 && y_out == '0 && !saturated && !invalid_pixel, "bad pole word")
  `MTP_ASSERT_NOW(a_count_sign, clk, rst_n, out_valid && !invalid_pixel, !count_out[CNT_W-1], "negative count on a valid pixel")

endmodule

bind mobius_transform_pixel_map mtp_checker u_mtp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .x_out         (out_ch.x_out),
  .y_out         (out_ch.y_out),
  .count_out     (out_ch.count_out),
  .invalid_pixel (out_ch.invalid_pixel),
  .pole_hit      (out_ch.pole_hit),
  .saturated     (out_ch.saturated)
);

// ===== test/tb.sv =====
module tb;
  import mtp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CALC_W = 256;
  localparam int PIPE_LAT = ST_LAST + 4;
  localparam longint CYCLE_LIMIT = 600000;
  localparam int CHOKE_CYCLES = 300;
  // Index outside the register file; the block must drop the write.
  localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(15);
  localparam logic signed [COORD_W-1:0] ONE_Q = COORD_W'(1 << FRAC_W);
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [CNT_W-1:0]   cnt;
  } pixel_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [CNT_W-1:0]   cnt;
    logic                      inv;
    logic                      pole;
    logic                      sat;
  } mapped_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [COORD_W-1:0] cfg_wdata;

  mtp_in_if  in_ch();
  mtp_out_if out_ch();

  mobius_transform_pixel_map i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  coef_t coefs;
  pixel_t pixel_queue[$];
  mapped_t mapped_queue[$];
  int n_sent, n_checked, n_mism, n_pole, n_inv, n_sat;
  int src_gap, sink_gap, choke_left, choke_arm, choke_seen;
  bit no_idle;
  longint cycles;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Signed quotient truncated toward zero and clipped to the coordinate range.
  function automatic logic [COORD_W-1:0] clip_quot(logic signed [CALC_W-1:0] num,
                                                   logic [CALC_W-1:0] den, inout logic sat);
    logic neg;
    logic [CALC_W-1:0] mag;
    logic [CALC_W-1:0] lim;
    logic [COORD_W-1:0] r;
    neg = num[CALC_W-1];
    mag = neg ? $unsigned(-num) : $unsigned(num);
    mag = mag / den;
    lim = neg ? (CALC_W'(1) << (COORD_W - 1)) : ((CALC_W'(1) << (COORD_W - 1)) - 1);
    if (mag > lim) begin
      sat = 1'b1;
      mag = lim;
    end
    r = mag[COORD_W-1:0];
    return neg ? -r : r;
  endfunction

  function automatic mapped_t mobius_map(pixel_t p);
    mapped_t r;
    logic signed [CALC_W-1:0] zx, zy, ar, ai, br, bi, cr, ci, dr, di;
    logic signed [CALC_W-1:0] nr, ni, mr, mi, den, pre, pim;
    logic sat;
    r.inv = 1'b0;
    r.pole = 1'b0;
    r.sat = 1'b0;
    if (p.cnt[CNT_W-1]) begin
      r.x = MARK_COORD;
      r.y = MARK_COORD;
      r.cnt = MARK_CNT;
      r.inv = 1'b1;
      return r;
    end
    r.cnt = p.cnt;
    zx = p.x;
    zy = p.y;
    ar = $signed(coefs.a_re);
    ai = $signed(coefs.a_im);
    br = $signed(coefs.b_re);
    bi = $signed(coefs.b_im);
    cr = $signed(coefs.c_re);
    ci = $signed(coefs.c_im);
    dr = $signed(coefs.d_re);
    di = $signed(coefs.d_im);
    nr = ar * zx - ai * zy + (br <<< FRAC_W);
    ni = ar * zy + ai * zx + (bi <<< FRAC_W);
    mr = cr * zx - ci * zy + (dr <<< FRAC_W);
    mi = cr * zy + ci * zx + (di <<< FRAC_W);
    den = mr * mr + mi * mi;
    if (den == 0) begin
      r.x = '0;
      r.y = '0;
      r.pole = 1'b1;
      return r;
    end
    pre = (nr * mr + ni * mi) <<< FRAC_W;
    pim = (ni * mr - nr * mi) <<< FRAC_W;
    sat = 1'b0;
    r.x = clip_quot(pre, den, sat);
    r.y = clip_quot(pim, den, sat);
    r.sat = sat;
    return r;
  endfunction

  // Source side: a word stays on the bus until it is taken.
  always @(posedge clk) begin
    logic offer;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      src_gap = 0;
    end else begin
      offer = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        mapped_queue.push_back(mobius_map(pixel_queue.pop_front()));
        n_sent++;
        src_gap = gap_len();
      end else if (in_ch.valid) begin
        offer = 1'b1;
      end
      if (!offer) begin
        if (src_gap > 0) src_gap--;
        else if (pixel_queue.size() > 0) offer = 1'b1;
      end
      if (offer) begin
        in_ch.x_in <= pixel_queue[0].x;
        in_ch.y_in <= pixel_queue[0].y;
        in_ch.count_in <= pixel_queue[0].cnt;
      end
      in_ch.valid <= offer;
    end
  end

  // Sink side: random back-pressure plus an occasional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      choke_left <= 0;
      choke_seen <= 0;
      sink_gap <= 0;
    end else if (choke_left > 0) begin
      choke_left <= choke_left - 1;
      out_ch.ready <= 1'b0;
    end else if (choke_arm != choke_seen) begin
      choke_seen <= choke_arm;
      choke_left <= CHOKE_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) sink_gap <= gap_len();
    end
  end

  always @(posedge clk) begin
    mapped_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (mapped_queue.size() == 0) begin
        n_mism++;
        if (n_mism <= 10) $display("unexpected word: x=%0d y=%0d", out_ch.x_out, out_ch.y_out);
      end else begin
        e = mapped_queue.pop_front();
        n_checked++;
        n_pole += e.pole;
        n_inv += e.inv;
        n_sat += e.sat;
        if (out_ch.x_out !== e.x || out_ch.y_out !== e.y || out_ch.count_out !== e.cnt ||
            out_ch.invalid_pixel !== e.inv || out_ch.pole_hit !== e.pole ||
            out_ch.saturated !== e.sat) begin
          n_mism++;
          if (n_mism <= 10)
            $display("mismatch word %0d: exp x=%0d y=%0d cnt=%0d inv=%b pole=%b sat=%b",
                     n_checked, e.x, e.y, e.cnt, e.inv, e.pole, e.sat,
                     " got x=%0d y=%0d cnt=%0d inv=%b pole=%b sat=%b",
                     out_ch.x_out, out_ch.y_out, out_ch.count_out,
                     out_ch.invalid_pixel, out_ch.pole_hit, out_ch.saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[mobius_transform_pixel_map] ERROR");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pixel_queue.size() > 0 || mapped_queue.size() > 0 || in_ch.valid) @(posedge clk);
    repeat (PIPE_LAT) @(posedge clk);
  endtask

  task automatic write_coef(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_A_RE: coefs.a_re = val;
      REG_A_IM: coefs.a_im = val;
      REG_B_RE: coefs.b_re = val;
      REG_B_IM: coefs.b_im = val;
      REG_C_RE: coefs.c_re = val;
      REG_C_IM: coefs.c_im = val;
      REG_D_RE: coefs.d_re = val;
      REG_D_IM: coefs.d_im = val;
      default: ;
    endcase
  endtask

  task automatic load_coefs(coef_t c);
    write_coef(REG_A_RE, c.a_re);
    write_coef(REG_A_IM, c.a_im);
    write_coef(REG_B_RE, c.b_re);
    write_coef(REG_B_IM, c.b_im);
    write_coef(REG_C_RE, c.c_re);
    write_coef(REG_C_IM, c.c_im);
    write_coef(REG_D_RE, c.d_re);
    write_coef(REG_D_IM, c.d_im);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_pixel(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                           logic signed [CNT_W-1:0] cnt);
    pixel_t p;
    p.x = x;
    p.y = y;
    p.cnt = cnt;
    pixel_queue.push_back(p);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord(int style);
    if (style == 0) return $urandom();
    return COORD_W'($signed($urandom_range(0, 8 << FRAC_W)) - (4 << FRAC_W));
  endfunction

  function automatic logic [CNT_W-1:0] rand_count();
    if ($urandom_range(0, 6) == 0) return CNT_W'(-$urandom_range(1, 1024));
    return CNT_W'($urandom_range(0, 1023));
  endfunction

  initial begin
    coef_t c;
    int style;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.x_in = '0;
    in_ch.y_in = '0;
    in_ch.count_in = '0;
    out_ch.ready = 1'b0;
    coefs = '0;
    no_idle = 1'b0;
    choke_arm = 0;
    cycles = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // All coefficients zero after reset: every valid pixel hits the pole.
    add_pixel(ONE_Q, -ONE_Q, CNT_W'(0));
    add_pixel(C_MAX, C_MIN, CNT_W'(1023));
    add_pixel('0, '0, CNT_W'(-1));
    wait_drained();

    // Identity map, plus a write to an index outside the register file.
    c = '0;
    c.a_re = ONE_Q;
    c.d_re = ONE_Q;
    load_coefs(c);
    write_coef(REG_UNUSED, C_MAX);
    @(posedge clk);
    cfg_we <= 1'b0;
    add_pixel(C_MAX, C_MAX, CNT_W'(1023));
    add_pixel(C_MIN, C_MIN, CNT_W'(0));
    add_pixel(C_MAX, C_MIN, CNT_W'(-1024));
    add_pixel('0, '0, CNT_W'(-1000));
    add_pixel(32'h5555_aaaa, 32'haaaa_5555, CNT_W'(11'h2aa));
    add_pixel(-32'sd1, 32'sd1, CNT_W'(11'h155));
    wait_drained();

    // Inversion 1/z: the origin is a pole, tiny points saturate.
    c = '0;
    c.b_re = ONE_Q;
    c.c_re = ONE_Q;
    load_coefs(c);
    add_pixel('0, '0, CNT_W'(3));
    add_pixel(32'sd1, '0, CNT_W'(4));
    add_pixel('0, -32'sd1, CNT_W'(5));
    add_pixel(ONE_Q, ONE_Q, CNT_W'(6));
    add_pixel(C_MIN, C_MAX, CNT_W'(7));
    add_pixel(-ONE_Q, ONE_Q, CNT_W'(-5));
    wait_drained();

    // Extreme coefficients on both ends.
    c = {C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX};
    load_coefs(c);
    add_pixel(C_MAX, C_MAX, CNT_W'(1));
    add_pixel(C_MIN, C_MIN, CNT_W'(2));
    add_pixel(ONE_Q, '0, CNT_W'(3));
    add_pixel('0, '0, CNT_W'(4));
    wait_drained();

    for (int ph = 0; ph < 12; ph++) begin
      style = $urandom_range(0, 3);
      c.a_re = rand_coord(style & 1);
      c.a_im = rand_coord(style & 1);
      c.b_re = rand_coord(style & 1);
      c.b_im = rand_coord(style & 1);
      c.c_re = (style == 2) ? '0 : rand_coord(style & 1);
      c.c_im = (style == 2) ? '0 : rand_coord(style & 1);
      c.d_re = rand_coord(style >> 1);
      c.d_im = rand_coord(style >> 1);
      load_coefs(c);
      no_idle = (ph == 5);
      for (int k = 0; k < 61; k++) begin
        style = $urandom_range(0, 1);
        add_pixel(rand_coord(style), rand_coord(style), rand_count());
      end
      if (ph == 3 || ph == 8) choke_arm++;
      wait_drained();
    end
    no_idle = 1'b0;

    $display("sent %0d pixels, checked %0d words: %0d poles, %0d invalid, %0d saturated",
             n_sent, n_checked, n_pole, n_inv, n_sat);
    if (n_mism == 0 && mapped_queue.size() == 0) begin
      $display("[mobius_transform_pixel_map] OK");
    end else begin
      $display("%0d mismatches, %0d words still owed", n_mism, mapped_queue.size());
      $display("[mobius_transform_pixel_map] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/mtp_pkg.sv
sv/mtp_if.sv
sv/mtp_cfg_regs.sv
sv/mtp_front.sv
sv/mtp_wmul.sv
sv/mtp_div.sv
sv/mobius_transform_pixel_map.sv
sv/mtp_checker.sv
test/tb.sv
